[src/h2rgb_pkg.sv]
// ----------------------------------------------------------------------------
// h2rgb_pkg
// shared types and constants of the hsv to rgb converter
// ----------------------------------------------------------------------------
package h2rgb_pkg;

  localparam int unsigned H2RGB_QUEUE_DEPTH = 2;

  localparam int unsigned DEG_FULL   = 360;
  localparam int unsigned DEG_SECTOR = 60;
  localparam int unsigned PCT_MAX    = 100;

  // 92 * 360, keeps the biased hue positive
  localparam logic [16:0] HUE_BIAS = 17'd33120;

  // floor(u / 360) = (u * 93207) >> 25 for u < 2^17
  localparam logic [16:0] DEG_FULL_RECIP = 17'd93207;
  localparam int unsigned DEG_FULL_SHIFT = 25;

  // floor(h / 60) = (h * 1093) >> 16 for h < 360
  localparam logic [19:0] DEG_SECTOR_RECIP = 20'd1093;
  localparam int unsigned DEG_SECTOR_SHIFT = 16;

  // 1.0 = 600000 units, value * 6000 is v in units
  localparam logic [19:0] VAL_UNIT = 20'd6000;

  // floor(units * 255 / 600000) = (units * 14602889) >> 35
  localparam logic [23:0] CHAN_RECIP = 24'd14602889;
  localparam int unsigned CHAN_SHIFT = 35;

  typedef enum logic [2:0] {
    SEC_R_TO_Y = 3'd0,
    SEC_Y_TO_G = 3'd1,
    SEC_G_TO_C = 3'd2,
    SEC_C_TO_B = 3'd3,
    SEC_B_TO_M = 3'd4,
    SEC_M_TO_R = 3'd5
  } hue_sector_e;

  typedef struct packed {
    logic [8:0] hue_deg;
    logic [6:0] sat;
    logic [6:0] val;
  } h2rgb_item_t;

endpackage

[src/h2rgb_if.sv]
// ----------------------------------------------------------------------------
// h2rgb_if
// request channels of the converter: hsv in, rgb out
// ----------------------------------------------------------------------------
interface hsv_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] hue;
  logic signed [7:0]  saturation;
  logic signed [7:0]  brightness_value;

  modport source (output valid, hue, saturation, brightness_value, input ready);
  modport sink   (input valid, hue, saturation, brightness_value, output ready);
endinterface

interface rgb_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [23:0] packed_rgb;

  modport source (output valid, red, green, blue, packed_rgb, input ready);
  modport sink   (input valid, red, green, blue, packed_rgb, output ready);
endinterface

[src/h2rgb_front.sv]
// ----------------------------------------------------------------------------
// h2rgb_front
// accepts requests, reduces hue modulo 360 and clamps the percentages
// ----------------------------------------------------------------------------
module h2rgb_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  hsv_if.sink                    hsv_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output h2rgb_pkg::h2rgb_item_t item_o
);
  import h2rgb_pkg::*;

  logic        s1_ready, s2_ready;
  logic        s1_valid_q, s2_valid_q;
  logic [16:0] s1_biased_d, s1_biased_q;
  logic [33:0] s1_quot_prod;
  logic [7:0]  s1_quot_d, s1_quot_q;
  logic [6:0]  s1_sat_d, s1_sat_q, s1_val_d, s1_val_q;
  logic [16:0] s2_hue_full;
  h2rgb_item_t s2_item_d, s2_item_q;

  function automatic logic [6:0] clamp_pct(logic signed [7:0] p);
    logic [6:0] res;
    if (p[7]) begin
      res = 7'd0;
    end else if (p > 8'sd100) begin
      res = 7'(PCT_MAX);
    end else begin
      res = p[6:0];
    end
    return res;
  endfunction

  assign s2_ready    = !s2_valid_q || ready_i;
  assign s1_ready    = !s1_valid_q || s2_ready;
  assign hsv_i.ready = s1_ready;

  // biased hue and quotient by 360
  always_comb begin
    s1_biased_d  = {hsv_i.hue[15], hsv_i.hue} + HUE_BIAS;
    s1_quot_prod = 34'(s1_biased_d) * 34'(DEG_FULL_RECIP);
    s1_quot_d    = s1_quot_prod[DEG_FULL_SHIFT +: 8];
    s1_sat_d     = clamp_pct(hsv_i.saturation);
    s1_val_d     = clamp_pct(hsv_i.brightness_value);
  end

  // remainder by 360
  always_comb begin
    s2_hue_full       = s1_biased_q - (17'(s1_quot_q) * 17'(DEG_FULL));
    s2_item_d.hue_deg = s2_hue_full[8:0];
    s2_item_d.sat     = s1_sat_q;
    s2_item_d.val     = s1_val_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= hsv_i.valid;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (hsv_i.valid && s1_ready) begin
      s1_biased_q <= s1_biased_d;
      s1_quot_q   <= s1_quot_d;
      s1_sat_q    <= s1_sat_d;
      s1_val_q    <= s1_val_d;
    end
    if (s1_valid_q && s2_ready) begin
      s2_item_q <= s2_item_d;
    end
  end

  assign valid_o = s2_valid_q;
  assign item_o  = s2_item_q;

`ifndef ASSERT_OFF
  a_hue_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> (s2_item_q.hue_deg < 9'(DEG_FULL)))
    else $error("hue not reduced below 360");
`endif

endmodule

[src/h2rgb_fifo.sv]
// ----------------------------------------------------------------------------
// h2rgb_fifo
// short queue between the front and the back
// ----------------------------------------------------------------------------
module h2rgb_fifo #(
  parameter int unsigned Depth = h2rgb_pkg::H2RGB_QUEUE_DEPTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  h2rgb_pkg::h2rgb_item_t item_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output h2rgb_pkg::h2rgb_item_t item_o
);
  import h2rgb_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  h2rgb_item_t         entries_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;
  logic                push, pop;

  assign ready_o = (count_q != CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign push    = valid_i && ready_o;
  assign pop     = valid_o && ready_i;
  assign item_o  = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= item_i;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count beyond depth");
  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count missed a push");
  a_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> (count_q == $past(count_q) - 1'b1))
    else $error("queue count missed a pop");
`endif

endmodule

[src/h2rgb_back.sv]
// ----------------------------------------------------------------------------
// h2rgb_back
// sector split, chroma and offset terms, scaling to 8-bit channels
// ----------------------------------------------------------------------------
module h2rgb_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  h2rgb_pkg::h2rgb_item_t item_i,
  rgb_if.source                  rgb_o
);
  import h2rgb_pkg::*;

  logic        b1_ready, b2_ready, out_ready;
  logic        b1_valid_q, b2_valid_q, out_valid_q;

  logic [19:0] sect_prod;
  logic [2:0]  sector_d;
  logic [8:0]  rem_full;
  logic [5:0]  rem;
  logic [5:0]  frac_d;
  logic [13:0] vs_d;

  logic [2:0]  b1_sector_q;
  logic [5:0]  b1_frac_q;
  logic [13:0] b1_vs_q;
  logic [6:0]  b1_val_q;

  logic [19:0] chroma, second, offset;
  logic [19:0] units_r_d, units_g_d, units_b_d;
  logic [19:0] units_r_q, units_g_q, units_b_q;

  logic [43:0] prod_r, prod_g, prod_b;
  logic [7:0]  red_q, green_q, blue_q;

  assign out_ready = !out_valid_q || rgb_o.ready;
  assign b2_ready  = !b2_valid_q || out_ready;
  assign b1_ready  = !b1_valid_q || b2_ready;
  assign ready_o   = b1_ready;

  // sector and position within it
  always_comb begin
    sect_prod = 20'(item_i.hue_deg) * DEG_SECTOR_RECIP;
    sector_d  = sect_prod[DEG_SECTOR_SHIFT +: 3];
    rem_full  = item_i.hue_deg - (9'(sector_d) * 9'(DEG_SECTOR));
    rem       = rem_full[5:0];
    frac_d    = sector_d[0] ? (6'(DEG_SECTOR) - rem) : rem;
    vs_d      = 14'(item_i.sat) * 14'(item_i.val);
  end

  // chroma, secondary and offset, then sector mapping
  always_comb begin
    chroma    = 20'(b1_vs_q) * 20'(DEG_SECTOR);
    second    = 20'(b1_vs_q) * 20'(b1_frac_q);
    offset    = (20'(b1_val_q) * VAL_UNIT) - chroma;
    units_r_d = offset;
    units_g_d = offset;
    units_b_d = offset;
    case (hue_sector_e'(b1_sector_q))
      SEC_R_TO_Y: begin
        units_r_d = chroma + offset;
        units_g_d = second + offset;
      end
      SEC_Y_TO_G: begin
        units_r_d = second + offset;
        units_g_d = chroma + offset;
      end
      SEC_G_TO_C: begin
        units_g_d = chroma + offset;
        units_b_d = second + offset;
      end
      SEC_C_TO_B: begin
        units_g_d = second + offset;
        units_b_d = chroma + offset;
      end
      SEC_B_TO_M: begin
        units_r_d = second + offset;
        units_b_d = chroma + offset;
      end
      default: begin
        units_r_d = chroma + offset;
        units_b_d = second + offset;
      end
    endcase
  end

  // units to 0..255
  assign prod_r = 44'(units_r_q) * 44'(CHAN_RECIP);
  assign prod_g = 44'(units_g_q) * 44'(CHAN_RECIP);
  assign prod_b = 44'(units_b_q) * 44'(CHAN_RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q  <= 1'b0;
      b2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (b1_ready) begin
        b1_valid_q <= valid_i;
      end
      if (b2_ready) begin
        b2_valid_q <= b1_valid_q;
      end
      if (out_ready) begin
        out_valid_q <= b2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && b1_ready) begin
      b1_sector_q <= sector_d;
      b1_frac_q   <= frac_d;
      b1_vs_q     <= vs_d;
      b1_val_q    <= item_i.val;
    end
    if (b1_valid_q && b2_ready) begin
      units_r_q <= units_r_d;
      units_g_q <= units_g_d;
      units_b_q <= units_b_d;
    end
    if (b2_valid_q && out_ready) begin
      red_q   <= prod_r[CHAN_SHIFT +: 8];
      green_q <= prod_g[CHAN_SHIFT +: 8];
      blue_q  <= prod_b[CHAN_SHIFT +: 8];
    end
  end

  assign rgb_o.valid      = out_valid_q;
  assign rgb_o.red        = red_q;
  assign rgb_o.green      = green_q;
  assign rgb_o.blue       = blue_q;
  assign rgb_o.packed_rgb = {red_q, green_q, blue_q};

`ifndef ASSERT_OFF
  a_sector_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b1_valid_q |-> (b1_sector_q <= 3'(SEC_M_TO_R)))
    else $error("hue sector out of range");
`endif

endmodule

[src/hsv_to_rgb_color.sv]
// path: a request is registered in front s1 and s2, the queue, then back b1, b2 and the output
// throughput: one request per clock while rgb_o.ready does not stall; the channel multipliers of the back
// stages and the front hue reduction all run in every cycle
// reset: asynchronous, clears only the valid flags, the queue count and the queue pointers
// ----------------------------------------------------------------------------
// hsv_to_rgb_color
// hsv in degrees and percent to 8-bit rgb and packed 0xRRGGBB word
// ----------------------------------------------------------------------------
module hsv_to_rgb_color #(
  parameter int unsigned QueueDepth = h2rgb_pkg::H2RGB_QUEUE_DEPTH
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  hsv_if.sink   hsv_i,
  rgb_if.source rgb_o
);
  import h2rgb_pkg::*;

  logic        front_valid, front_ready;
  logic        back_valid, back_ready;
  h2rgb_item_t front_item, back_item;

  h2rgb_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .hsv_i   (hsv_i),
    .valid_o (front_valid),
    .ready_i (front_ready),
    .item_o  (front_item)
  );

  h2rgb_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front_valid),
    .ready_o (front_ready),
    .item_i  (front_item),
    .valid_o (back_valid),
    .ready_i (back_ready),
    .item_o  (back_item)
  );

  h2rgb_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (back_valid),
    .ready_o (back_ready),
    .item_i  (back_item),
    .rgb_o   (rgb_o)
  );

endmodule
